FILE: rtl/core/desi_pkg.sv
// Shared types and constants for the directed edge-set insert block.
package desi_pkg;

    localparam int DEF_MAX_VERTICES = 16;

    localparam logic [1:0] ST_ADDED   = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic signed [31:0] from_vertex;
        logic signed [31:0] to_vertex;
    } t_edge_req;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] from_slot;
        logic [3:0] to_slot;
        logic       from_created;
        logic       to_created;
    } t_edge_rsp;

endpackage

FILE: rtl/core/directed_edge_set_insert_top.sv
// Top level of the directed edge-set insert block: sequencer, vertex table and edge matrix.
//
// Usage
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one request: a directed
//   edge given as two 32-bit vertex labels. Output channel (o_out_valid / i_out_ready /
//   o_out_data) returns exactly one response per request: status, both table slots and
//   the two "newly registered" flags.
//   One request is worked on at a time. A single pair of label comparators is walked
//   over the registered vertex slots, one slot per cycle through the vertex table's
//   read port; labels are then registered through its single write port and the edge
//   row is read, modified and written back through the matrix port.
//   The time from acceptance to response valid grows with the number of registered
//   vertices, since the scan reads each of them; on an empty table the scan issues no
//   read. A full-table response skips the S_ADD_TO, S_ROW_RD and S_ROW_UPD states.
//   A new request is taken only once the previous response has entered the output
//   register, so requests are not overlapped.
//   The output register holds the response while the receiver stalls; the block still
//   accepts and works on the next request, and waits before its own response only if
//   the previous one has not yet been taken.
//   Reset (synchronous, active low) empties the vertex table and clears every edge row
//   at once through per-row valid bits; no clearing pass is needed.
module directed_edge_set_insert_top
    import desi_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_edge_req i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_edge_rsp o_out_data
);

    localparam int SW = $clog2(MAX_VERTICES);       // slot index width
    localparam int CW = $clog2(MAX_VERTICES + 1);   // count width, holds MAX_VERTICES

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_SCAN    = 7'b0000010,
        S_DECIDE  = 7'b0000100,
        S_ADD_TO  = 7'b0001000,
        S_ROW_RD  = 7'b0010000,
        S_ROW_UPD = 7'b0100000,
        S_RESULT  = 7'b1000000
    } t_state;

    // Vertex label table and edge matrix, one row per source slot.
    logic [31:0]             label_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] edge_mem  [MAX_VERTICES];

    // Control registers
    t_state                  r_state,     n_state;
    logic [CW-1:0]           r_count,     n_count;
    logic [CW-1:0]           r_idx,       n_idx;
    logic                    r_rd_vld,    n_rd_vld;
    logic [MAX_VERTICES-1:0] r_row_valid, n_row_valid;
    logic                    r_out_valid, n_out_valid;

    // Payload registers
    logic [31:0]             r_a, n_a;
    logic [31:0]             r_b, n_b;
    logic [SW-1:0]           r_rd_slot, n_rd_slot;
    logic                    r_fa, n_fa;
    logic                    r_fb, n_fb;
    logic [SW-1:0]           r_sa, n_sa;
    logic [SW-1:0]           r_sb, n_sb;
    logic                    r_ca, n_ca;
    logic                    r_cb, n_cb;
    t_edge_rsp               r_res, n_res;
    t_edge_rsp               r_out, n_out;

    // Memory read data (registered) and port controls
    logic [31:0]             r_rd_label;
    logic [MAX_VERTICES-1:0] r_row;
    logic                    lbl_re, lbl_we;
    logic [SW-1:0]           lbl_ra, lbl_wa;
    logic [31:0]             lbl_wd;
    logic                    row_re, row_we;
    logic [MAX_VERTICES-1:0] row_wd;

    // Decision helpers
    logic [1:0]              need;
    logic [CW-1:0]           free_slots;
    logic [MAX_VERTICES-1:0] cur_row;
    logic [MAX_VERTICES-1:0] edge_mask;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Labels to register: one per missing label, a self-loop needs only one.
    always_comb begin
        if (!r_fa && !r_fb && r_a == r_b) begin
            need = 2'd1;
        end else begin
            need = 2'({1'b0, !r_fa} + {1'b0, !r_fb});
        end
        free_slots = CW'(MAX_VERTICES) - r_count;
        cur_row    = r_row_valid[r_sa] ? r_row : '0;
        edge_mask  = MAX_VERTICES'(1) << r_sb;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_rd_vld    = 1'b0;
        n_row_valid = r_row_valid;
        n_out_valid = r_out_valid && !i_out_ready;
        n_a         = r_a;
        n_b         = r_b;
        n_rd_slot   = r_rd_slot;
        n_fa        = r_fa;
        n_fb        = r_fb;
        n_sa        = r_sa;
        n_sb        = r_sb;
        n_ca        = r_ca;
        n_cb        = r_cb;
        n_res       = r_res;
        n_out       = r_out;
        lbl_re      = 1'b0;
        lbl_ra      = r_idx[SW-1:0];
        lbl_we      = 1'b0;
        lbl_wa      = r_count[SW-1:0];
        lbl_wd      = r_a;
        row_re      = 1'b0;
        row_we      = 1'b0;
        row_wd      = cur_row | edge_mask;

        unique case (r_state)
            S_IDLE: begin
                // Take a new request; the previous response may still sit in the output register.
                if (i_in_valid) begin
                    n_a     = i_in_data.from_vertex;
                    n_b     = i_in_data.to_vertex;
                    n_idx   = '0;
                    n_fa    = 1'b0;
                    n_fb    = 1'b0;
                    n_sa    = '0;
                    n_sb    = '0;
                    n_ca    = 1'b0;
                    n_cb    = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // Issue one slot read per cycle, compare the slot read in the previous cycle.
                if (r_idx < r_count) begin
                    lbl_re    = 1'b1;
                    n_rd_vld  = 1'b1;
                    n_rd_slot = r_idx[SW-1:0];
                    n_idx     = r_idx + CW'(1);
                end
                if (r_rd_vld) begin
                    if (!r_fa && r_rd_label == r_a) begin
                        n_fa = 1'b1;
                        n_sa = r_rd_slot;
                    end
                    if (!r_fb && r_rd_label == r_b) begin
                        n_fb = 1'b1;
                        n_sb = r_rd_slot;
                    end
                end
                if (r_idx >= r_count && !r_rd_vld) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (CW'(need) > free_slots) begin
                    // No room: report full and leave the state alone.
                    n_res.status       = ST_FULL;
                    n_res.from_slot    = '0;
                    n_res.to_slot      = '0;
                    n_res.from_created = 1'b0;
                    n_res.to_created   = 1'b0;
                    n_state            = S_RESULT;
                end else begin
                    if (!r_fa) begin
                        lbl_we  = 1'b1;
                        n_sa    = r_count[SW-1:0];
                        n_count = r_count + CW'(1);
                        n_ca    = 1'b1;
                    end
                    n_state = S_ADD_TO;
                end
            end
            S_ADD_TO: begin
                if (!r_fb) begin
                    if (r_a == r_b) begin
                        n_sb = r_sa;
                    end else begin
                        lbl_we  = 1'b1;
                        lbl_wd  = r_b;
                        n_sb    = r_count[SW-1:0];
                        n_count = r_count + CW'(1);
                        n_cb    = 1'b1;
                    end
                end
                n_state = S_ROW_RD;
            end
            S_ROW_RD: begin
                row_re  = 1'b1;
                n_state = S_ROW_UPD;
            end
            S_ROW_UPD: begin
                if ((cur_row & edge_mask) != '0) begin
                    n_res.status = ST_PRESENT;
                end else begin
                    row_we             = 1'b1;
                    n_row_valid[r_sa]  = 1'b1;
                    n_res.status       = ST_ADDED;
                end
                n_res.from_slot    = 4'(r_sa);
                n_res.to_slot      = 4'(r_sb);
                n_res.from_created = r_ca;
                n_res.to_created   = r_cb;
                n_state            = S_RESULT;
            end
            S_RESULT: begin
                // Hold until the output register is free, then hand the response over.
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_rd_vld    <= n_rd_vld;
            r_row_valid <= n_row_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a       <= n_a;
        r_b       <= n_b;
        r_rd_slot <= n_rd_slot;
        r_fa      <= n_fa;
        r_fb      <= n_fb;
        r_sa      <= n_sa;
        r_sb      <= n_sb;
        r_ca      <= n_ca;
        r_cb      <= n_cb;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    // Vertex label table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (lbl_we) begin
            label_mem[lbl_wa] <= lbl_wd;
        end
        if (lbl_re) begin
            r_rd_label <= label_mem[lbl_ra];
        end
    end

    // Edge matrix: read-modify-write of the source row.
    always_ff @(posedge i_clk) begin
        if (row_we) begin
            edge_mem[r_sa] <= row_wd;
        end
        if (row_re) begin
            r_row <= edge_mem[r_sa];
        end
    end

    // The vertex count never passes the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_VERTICES))
        else $error("vertex count beyond table size");

    // The count only grows between resets.
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count >= $past(r_count))
        else $error("vertex count decreased");

    // A full response reports no slots and no new vertices.
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_FULL) |->
        (o_out_data.from_slot == 4'd0 && o_out_data.to_slot == 4'd0 &&
         !o_out_data.from_created && !o_out_data.to_created))
        else $error("full response carries slot data");

    // A newly registered vertex cannot already own the edge.
    a_new_added: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.from_created || o_out_data.to_created)) |->
        o_out_data.status == ST_ADDED)
        else $error("new vertex reported with existing edge");

    // After a request is taken the block stays busy for the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready while a request is in progress");

endmodule
